// ===== sv/prr_pkg.sv =====
// ----------------------------------------------------------------------------
// prr_pkg
// Shared types and constants for the proportional rate reduction block.
// ----------------------------------------------------------------------------
package prr_pkg;

    // fixed field widths
    localparam int ACK_BITS   = 16;
    localparam int DELIV_BITS = 32;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // capture the input word, update delivered count
        logic mul;       // threshold * delivered, non-proportional candidate
        logic prep;      // form dividend, start divider
        logic div_step;  // one quotient bit
        logic fin;       // pick and clamp the send count
        logic out_load;  // load the result register
    } prr_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic prop;      // proportional case, divider needed
        logic div_last;  // current divider step is the last one
    } prr_status_t;

endpackage

// ===== sv/prr_ctrl.sv =====
// ----------------------------------------------------------------------------
// prr_ctrl
// Sequencer: steps one word through multiply, divide (proportional case only) and finish.
// ----------------------------------------------------------------------------
module prr_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    output logic                 result_valid,
    input  logic                 result_stall,
    input  prr_pkg::prr_status_t status,
    output prr_pkg::prr_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       result_valid_reg;
    logic       result_valid_next;
    logic       out_free;

    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = status.prop ? S_PREP : S_FIN;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_stall)
        begin
            result_valid_next = result_valid_reg;
        end
        else
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;

    // accepted word always goes on to the multiply step
    a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == S_MUL))
        else $error("accepted word did not enter multiply step");

    // result register is never overwritten while a word waits there
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!result_valid_reg || !result_stall))
        else $error("result register overwritten under stall");

    // divider runs only in the proportional case
    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && status.prop) |=> (state_reg == S_PREP))
        else $error("proportional case skipped the divider");

    // no new word while the previous one is still inside
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> item_stall)
        else $error("input open during divide");

endmodule

// ===== sv/prr_dp.sv =====
// ----------------------------------------------------------------------------
// prr_dp
// Datapath: delivered counter, multiplier, restoring divider, result regs.
// ----------------------------------------------------------------------------
module prr_dp
#(
    parameter int WINDOW_BITS = 20
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  prr_pkg::prr_cmd_t                   cmd,
    output prr_pkg::prr_status_t                status,
    input  logic                                restart_recovery,
    input  logic [prr_pkg::ACK_BITS-1:0]        acked_count,
    input  logic                                retrans_data_acked,
    input  logic                                lost_retrans,
    input  logic [WINDOW_BITS-1:0]              slow_start_threshold,
    input  logic [WINDOW_BITS-1:0]              prior_window,
    input  logic [WINDOW_BITS-1:0]              sent_in_recovery,
    input  logic [WINDOW_BITS-1:0]              flight_size,
    output logic                                window_updated,
    output logic [WINDOW_BITS:0]                new_window,
    output logic [WINDOW_BITS-1:0]              send_count
);

    localparam int W  = WINDOW_BITS;
    localparam int DB = prr_pkg::DELIV_BITS;
    localparam int AB = prr_pkg::ACK_BITS;
    localparam int DW = W + DB;          // dividend / quotient width
    localparam int SW = DW + 2;          // signed send-count width
    localparam int CW = $clog2(DW);

    // delivered count (block state)
    logic [DB-1:0] del_reg;
    logic [DB-1:0] del_next;

    // captured word
    logic          skip_reg;
    logic          prop_reg;
    logic          rda_reg;
    logic          lost_reg;
    logic [AB-1:0] acked_reg;
    logic [W-1:0]  ssth_reg;
    logic [W-1:0]  prior_reg;
    logic [W-1:0]  sent_reg;
    logic [W-1:0]  flight_reg;

    // arithmetic
    logic [DW-1:0] prod_reg;
    logic [SW-1:0] alt_reg;
    logic [W-1:0]  rem_reg;
    logic [DW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic [SW-1:0] snd_reg;

    // result
    logic          window_updated_reg;
    logic [W:0]    new_window_reg;
    logic [W-1:0]  send_count_reg;

    // load stage
    logic [DB-1:0] del_base;
    logic [DB:0]   del_sum;
    logic          skip_now;

    assign del_base = restart_recovery ? '0 : del_reg;
    assign del_sum  = {1'b0, del_base} + {{(DB + 1 - AB){1'b0}}, acked_count};
    assign skip_now = (acked_count == '0) || (prior_window == '0);

    always_comb
    begin
        if (skip_now)
        begin
            del_next = del_base;
        end
        else if (del_sum[DB])
        begin
            del_next = '1;
        end
        else
        begin
            del_next = del_sum[DB-1:0];
        end
    end

    // zero-extended operands
    logic [SW-1:0] ssth_x;
    logic [SW-1:0] flight_x;
    logic [SW-1:0] sent_x;
    logic [SW-1:0] acked_x;
    logic [SW-1:0] del_x;

    assign ssth_x   = {{(SW - W){1'b0}}, ssth_reg};
    assign flight_x = {{(SW - W){1'b0}}, flight_reg};
    assign sent_x   = {{(SW - W){1'b0}}, sent_reg};
    assign acked_x  = {{(SW - AB){1'b0}}, acked_reg};
    assign del_x    = {{(SW - DB){1'b0}}, del_reg};

    // multiply step: product and the two non-proportional candidates
    logic [DW-1:0] prod_w;
    logic [SW-1:0] delta;
    logic [SW-1:0] catch_base;
    logic [SW-1:0] catch_max;
    logic [SW-1:0] catch_inc;
    logic [SW-1:0] catch_snd;
    logic [SW-1:0] cons_snd;
    logic [SW-1:0] alt_next;

    assign prod_w     = {{(DW - W){1'b0}}, ssth_reg} * {{(DW - DB){1'b0}}, del_reg};
    assign delta      = ssth_x - flight_x;
    assign catch_base = del_x - sent_x;
    assign catch_max  = ($signed(catch_base) > $signed(acked_x)) ? catch_base : acked_x;
    assign catch_inc  = catch_max + {{(SW - 1){1'b0}}, 1'b1};
    assign catch_snd  = ($signed(delta) < $signed(catch_inc)) ? delta : catch_inc;
    assign cons_snd   = ($signed(delta) < $signed(acked_x)) ? delta : acked_x;
    assign alt_next   = (rda_reg && !lost_reg) ? catch_snd : cons_snd;

    // divider step (restoring, one quotient bit per cycle)
    logic [W:0]    trial;
    logic [W:0]    trial_diff;
    logic          trial_ge;

    assign trial      = {rem_reg, quo_reg[DW-1]};
    assign trial_diff = trial - {1'b0, prior_reg};
    assign trial_ge   = (trial >= {1'b0, prior_reg});

    // finish step
    logic [SW-1:0] snd_sel;
    logic [SW-1:0] snd_low;
    logic [SW-1:0] snd_next;

    assign snd_sel  = prop_reg ? ({2'b00, quo_reg} - sent_x) : alt_reg;
    assign snd_low  = {{(SW - 1){1'b0}}, (sent_reg == '0)};
    assign snd_next = ($signed(snd_sel) < $signed(snd_low)) ? snd_low : snd_sel;

    // output saturation
    logic [SW-1:0] win_sum;
    logic [SW-1:0] nw_max;
    logic [SW-1:0] snd_max;

    assign win_sum = flight_x + snd_reg;
    assign nw_max  = {{(SW - W - 1){1'b0}}, {(W + 1){1'b1}}};
    assign snd_max = {{(SW - W){1'b0}}, {W{1'b1}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            del_reg <= '0;
        end
        else if (cmd.load)
        begin
            del_reg <= del_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            skip_reg   <= skip_now;
            prop_reg   <= (flight_size > slow_start_threshold);
            rda_reg    <= retrans_data_acked;
            lost_reg   <= lost_retrans;
            acked_reg  <= acked_count;
            ssth_reg   <= slow_start_threshold;
            prior_reg  <= prior_window;
            sent_reg   <= sent_in_recovery;
            flight_reg <= flight_size;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_w;
            alt_reg  <= alt_next;
        end
        if (cmd.prep)
        begin
            rem_reg <= '0;
            quo_reg <= prod_reg + {{(DW - W){1'b0}}, prior_reg} - {{(DW - 1){1'b0}}, 1'b1};
            cnt_reg <= CW'(DW - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_diff[W-1:0] : trial[W-1:0];
            quo_reg <= {quo_reg[DW-2:0], trial_ge};
            cnt_reg <= cnt_reg - {{(CW - 1){1'b0}}, 1'b1};
        end
        if (cmd.fin)
        begin
            snd_reg <= snd_next;
        end
        if (cmd.out_load)
        begin
            if (skip_reg)
            begin
                window_updated_reg <= 1'b0;
                new_window_reg     <= '0;
                send_count_reg     <= '0;
            end
            else
            begin
                window_updated_reg <= 1'b1;
                new_window_reg     <= (win_sum > nw_max) ? {(W + 1){1'b1}} : win_sum[W:0];
                send_count_reg     <= (snd_reg > snd_max) ? {W{1'b1}} : snd_reg[W-1:0];
            end
        end
    end

    assign status.prop     = prop_reg && !skip_reg;
    assign status.div_last = (cnt_reg == '0);

    assign window_updated = window_updated_reg;
    assign new_window     = new_window_reg;
    assign send_count     = send_count_reg;

    // partial remainder stays below the divisor throughout the divide
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < prior_reg))
        else $error("divider remainder out of range");

    // clamped send count is never negative on an updating word
    a_snd_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && !skip_reg) |-> !snd_reg[SW-1])
        else $error("negative send count reached output");

    // skipped words leave the delivered count alone unless restarted
    a_skip_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && skip_now && !restart_recovery) |=> $stable(del_reg))
        else $error("delivered count moved on a skipped word");

endmodule

// ===== sv/proportional_rate_reduction.sv =====
// ----------------------------------------------------------------------------
// proportional_rate_reduction
// Per-ack proportional rate reduction for loss recovery (send count, window).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall) carries one ack word: restart
//   flag, newly acked count, retransmit flags, threshold, prior window,
//   packets sent in recovery and packets in flight. Output channel
//   (result_valid / result_stall) returns exactly one word per ack.
//   A word is taken at a clock edge with valid high and stall low.
// Sequence:
//   One word at a time: a new ack is not taken until the previous one
//   has been written to the output register. Without division (in flight
//   not above threshold, or no update) a word steps through multiply,
//   finish and write. The proportional case adds a prepare step and runs
//   the restoring divider, one quotient bit per cycle over a
//   WINDOW_BITS+32 bit dividend, before finish and write.
// Reset:
//   rst_n clears the delivered counter, the sequencer and result_valid.
// Stall:
//   A result waits in the output register while result_stall is high;
//   the next ack is still accepted and computed meanwhile, and holds in
//   its final step until the output register frees up.
// ----------------------------------------------------------------------------
module proportional_rate_reduction
#(
    parameter int WINDOW_BITS = 20
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // ack words
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic                           restart_recovery,
    input  logic [prr_pkg::ACK_BITS-1:0]   acked_count,
    input  logic                           retrans_data_acked,
    input  logic                           lost_retrans,
    input  logic [WINDOW_BITS-1:0]         slow_start_threshold,
    input  logic [WINDOW_BITS-1:0]         prior_window,
    input  logic [WINDOW_BITS-1:0]         sent_in_recovery,
    input  logic [WINDOW_BITS-1:0]         flight_size,
    // result words
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic                           window_updated,
    output logic [WINDOW_BITS:0]           new_window,
    output logic [WINDOW_BITS-1:0]         send_count
);

    prr_pkg::prr_cmd_t    cmd;
    prr_pkg::prr_status_t status;

    // sequencer: accept, multiply, optional divide, finish, write
    prr_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // arithmetic, delivered counter and result register
    prr_dp #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_dp
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .status               (status),
        .restart_recovery     (restart_recovery),
        .acked_count          (acked_count),
        .retrans_data_acked   (retrans_data_acked),
        .lost_retrans         (lost_retrans),
        .slow_start_threshold (slow_start_threshold),
        .prior_window         (prior_window),
        .sent_in_recovery     (sent_in_recovery),
        .flight_size          (flight_size),
        .window_updated       (window_updated),
        .new_window           (new_window),
        .send_count           (send_count)
    );

endmodule
